@@ sv/ssd_pkg.sv @@
`default_nettype none
package ssd_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int LANES          = 4;
	localparam int IN_FIELD_W     = 32;
	localparam int IN_FIELDS      = 8;
	localparam int IN_DATA_W      = IN_FIELD_W * IN_FIELDS;
	localparam int DIST_W         = 33;
	localparam int OUT_DATA_W     = 40;
	localparam int TOL_W          = 32;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Control that travels beside the arithmetic.
	typedef struct packed {
		logic vld;
		logic meet;
	} ssd_tag_t;

endpackage
`default_nettype wire

@@ sv/ssd_front.sv @@
`default_nettype none
module ssd_front import ssd_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	parameter int SW = 4 * (CB + 1) + 2,
	parameter int NW = 2 * (CB + 1) + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_vld,
	input  wire logic [IN_DATA_W-1:0] in_data,
	input  wire logic [TOL_W-1:0]     tol,
	output ssd_tag_t                  out_tag,
	output logic [SW-1:0]             dvd [LANES],
	output logic [NW-1:0]             dvs [LANES]
);

	localparam int D  = CB + 1;
	localparam int PW = 2 * D;
	localparam int P  = 2 * D + 1;
	localparam int H  = (P + 1) / 2;

	logic signed [CB-1:0] cx [4];
	logic signed [CB-1:0] cy [4];

	logic signed [D-1:0] dx_s1 [LANES], dy_s1 [LANES], wx_s1 [LANES];
	logic signed [D-1:0] wy_s1 [LANES], rx_s1 [LANES], ry_s1 [LANES];

	logic signed [PW-1:0] dxwy_s2 [LANES], dywx_s2 [LANES], dxwx_s2 [LANES];
	logic signed [PW-1:0] dywy_s2 [LANES], dxdx_s2 [LANES], dydy_s2 [LANES];
	logic signed [PW-1:0] wxwx_s2 [LANES], wywy_s2 [LANES], rxrx_s2 [LANES];
	logic signed [PW-1:0] ryry_s2 [LANES];

	logic signed [P-1:0] cr_s3 [LANES], t_s3 [LANES], n_s3 [LANES];
	logic signed [P-1:0] e0_s3 [LANES], e1_s3 [LANES];

	logic [LANES-1:0] pos_s4, neg_s4, in_s4;
	logic [P-1:0]     crm_s4 [LANES], vm_s4 [LANES];
	logic [NW-1:0]    n_s4 [LANES];

	logic             meet_s5;
	logic [LANES-1:0] in_s5;
	logic [2*H-1:0]   hh_s5 [LANES], hl_s5 [LANES], ll_s5 [LANES];
	logic [NW-1:0]    n_s5 [LANES];
	logic [P-1:0]     vm_s5 [LANES];

	logic           vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic           meet_s6;
	logic           meet_c;
	logic signed [P-1:0] tolp;

	assign tolp = P'($signed({1'b0, tol}));

	for (genvar gp = 0; gp < 4; gp++) begin : g_pt
		assign cx[gp] = in_data[64*gp +: CB];
		assign cy[gp] = in_data[64*gp + 32 +: CB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Segments meet when neither pair of orientations is strictly same-signed.
	always_comb begin
		meet_c = !(pos_s4[0] && pos_s4[1]) && !(neg_s4[0] && neg_s4[1]) &&
			!(pos_s4[2] && pos_s4[3]) && !(neg_s4[2] && neg_s4[3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meet_s5 <= meet_c;
			meet_s6 <= meet_s5;
		end
	end

	assign out_tag = '{vld: vld_s6, meet: meet_s6};

	for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
		// Lane order: (a0,a1,b0), (a0,a1,b1), (b0,b1,a0), (b0,b1,a1).
		localparam int S0 = (gl < 2) ? 0 : 2;
		localparam int S1 = S0 + 1;
		localparam int PP = (gl < 2) ? gl + 2 : gl - 2;

		logic        ltol, gtol, tneg, nlt;
		logic        pos_c, neg_c;
		logic [P-1:0] crm_c;
		logic [2*H-1:0] mag;
		logic [H-1:0]   hi, lo;
		logic [4*H-1:0] sq;

		always_comb begin
			gtol  = cr_s3[gl] > tolp;
			ltol  = cr_s3[gl] < -tolp;
			tneg  = t_s3[gl] < -tolp;
			nlt   = n_s3[gl] < e0_s3[gl];
			pos_c = gtol || (!ltol && tneg);
			neg_c = !gtol && (ltol || (!tneg && nlt));
			crm_c = cr_s3[gl][P-1] ? P'(-cr_s3[gl]) : P'(cr_s3[gl]);
		end

		assign mag = (2*H)'(crm_s4[gl]);
		assign hi  = mag[2*H-1:H];
		assign lo  = mag[H-1:0];
		assign sq  = {hh_s5[gl], (2*H)'(0)} + ((4*H)'(hl_s5[gl]) << (H + 1)) +
			(4*H)'(ll_s5[gl]);

		always_ff @(posedge clk) begin
			if (en) begin
				dx_s1[gl] <= {cx[S1][CB-1], cx[S1]} - {cx[S0][CB-1], cx[S0]};
				dy_s1[gl] <= {cy[S1][CB-1], cy[S1]} - {cy[S0][CB-1], cy[S0]};
				wx_s1[gl] <= {cx[PP][CB-1], cx[PP]} - {cx[S0][CB-1], cx[S0]};
				wy_s1[gl] <= {cy[PP][CB-1], cy[PP]} - {cy[S0][CB-1], cy[S0]};
				rx_s1[gl] <= {cx[PP][CB-1], cx[PP]} - {cx[S1][CB-1], cx[S1]};
				ry_s1[gl] <= {cy[PP][CB-1], cy[PP]} - {cy[S1][CB-1], cy[S1]};

				dxwy_s2[gl] <= dx_s1[gl] * wy_s1[gl];
				dywx_s2[gl] <= dy_s1[gl] * wx_s1[gl];
				dxwx_s2[gl] <= dx_s1[gl] * wx_s1[gl];
				dywy_s2[gl] <= dy_s1[gl] * wy_s1[gl];
				dxdx_s2[gl] <= dx_s1[gl] * dx_s1[gl];
				dydy_s2[gl] <= dy_s1[gl] * dy_s1[gl];
				wxwx_s2[gl] <= wx_s1[gl] * wx_s1[gl];
				wywy_s2[gl] <= wy_s1[gl] * wy_s1[gl];
				rxrx_s2[gl] <= rx_s1[gl] * rx_s1[gl];
				ryry_s2[gl] <= ry_s1[gl] * ry_s1[gl];

				cr_s3[gl] <= P'(dxwy_s2[gl]) - P'(dywx_s2[gl]);
				t_s3[gl]  <= P'(dxwx_s2[gl]) + P'(dywy_s2[gl]);
				n_s3[gl]  <= P'(dxdx_s2[gl]) + P'(dydy_s2[gl]);
				e0_s3[gl] <= P'(wxwx_s2[gl]) + P'(wywy_s2[gl]);
				e1_s3[gl] <= P'(rxrx_s2[gl]) + P'(ryry_s2[gl]);

				pos_s4[gl] <= pos_c;
				neg_s4[gl] <= neg_c;
				// Foot of the perpendicular strictly inside the segment.
				in_s4[gl]  <= (n_s3[gl] > 0) && (t_s3[gl] > 0) && (t_s3[gl] < n_s3[gl]);
				crm_s4[gl] <= crm_c;
				n_s4[gl]   <= NW'(n_s3[gl]);
				vm_s4[gl]  <= (e0_s3[gl] <= e1_s3[gl]) ? P'(e0_s3[gl]) : P'(e1_s3[gl]);

				in_s5[gl] <= in_s4[gl];
				hh_s5[gl] <= hi * hi;
				hl_s5[gl] <= hi * lo;
				ll_s5[gl] <= lo * lo;
				n_s5[gl]  <= n_s4[gl];
				vm_s5[gl] <= vm_s4[gl];

				// Meeting lanes divide zero by one so the root comes out zero.
				if (meet_s5) begin
					dvd[gl] <= '0;
					dvs[gl] <= NW'(1);
				end else if (in_s5[gl]) begin
					dvd[gl] <= sq[SW-1:0];
					dvs[gl] <= n_s5[gl];
				end else begin
					dvd[gl] <= SW'(vm_s5[gl]);
					dvs[gl] <= NW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/ssd_div.sv @@
`default_nettype none
module ssd_div import ssd_pkg::*; #(
	parameter int SW = 4 * (COORD_BITS_DEF + 1) + 2,
	parameter int NW = 2 * (COORD_BITS_DEF + 1) + 1,
	parameter int QW = 2 * (COORD_BITS_DEF + 1)
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [SW-1:0] dvd,
	input  wire logic [NW-1:0] dvs,
	output logic      [QW-1:0] quo
);

	localparam int RW = SW + 1;

	logic [RW-1:0] rem_s [QW-1];
	logic [NW-1:0] dvs_s [QW-1];
	logic [QW-1:0] q_s   [QW];

	// One quotient bit per stage, most significant first.
	for (genvar gi = 0; gi < QW; gi++) begin : g_stage
		localparam int B = QW - 1 - gi;

		logic [RW-1:0] rem_in, shd, rem_nx;
		logic [NW-1:0] dvs_in;
		logic [QW-1:0] q_in;
		logic          ge;

		if (gi == 0) begin : g_first
			assign rem_in = RW'(dvd);
			assign dvs_in = dvs;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[gi-1];
			assign dvs_in = dvs_s[gi-1];
			assign q_in   = q_s[gi-1];
		end

		assign shd    = RW'(dvs_in) << B;
		assign ge     = rem_in >= shd;
		assign rem_nx = ge ? rem_in - shd : rem_in;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[gi] <= q_in | (QW'(ge) << B);
			end
		end

		if (gi < QW - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[gi] <= rem_nx;
					dvs_s[gi] <= dvs_in;
				end
			end
		end
	end

	assign quo = q_s[QW-1];

endmodule
`default_nettype wire

@@ sv/ssd_sqrt.sv @@
`default_nettype none
module ssd_sqrt import ssd_pkg::*; #(
	parameter int QW = 2 * (COORD_BITS_DEF + 1),
	parameter int RB = COORD_BITS_DEF + 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ssd_tag_t      in_tag,
	input  wire logic [QW-1:0] x [LANES],
	output ssd_tag_t           out_tag,
	output logic      [RB-1:0] root
);

	localparam int XW = 2 * RB;

	logic [QW-1:0] m01_s1, m23_s1, mn_s2;
	ssd_tag_t      tag_s1, tag_s2;
	ssd_tag_t      tag_s [RB];
	logic [XW-1:0] rem_s [RB-1];
	logic [RB-1:0] q_s   [RB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
		end
	end

	// Floor of the root is monotone: take the least square, then one root.
	always_ff @(posedge clk) begin
		if (en) begin
			m01_s1 <= (x[0] <= x[1]) ? x[0] : x[1];
			m23_s1 <= (x[2] <= x[3]) ? x[2] : x[3];
			mn_s2  <= (m01_s1 <= m23_s1) ? m01_s1 : m23_s1;
		end
	end

	for (genvar gi = 0; gi < RB; gi++) begin : g_stage
		localparam int B = RB - 1 - gi;

		logic [XW-1:0] rem_in, trial;
		logic [RB-1:0] q_in;
		ssd_tag_t      tag_in;
		logic          ge;

		if (gi == 0) begin : g_first
			assign rem_in = XW'(mn_s2);
			assign q_in   = '0;
			assign tag_in = tag_s2;
		end else begin : g_next
			assign rem_in = rem_s[gi-1];
			assign q_in   = q_s[gi-1];
			assign tag_in = tag_s[gi-1];
		end

		// (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
		assign trial = (XW'(q_in) << (B + 1)) | (XW'(1) << (2 * B));
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[gi] <= '0;
			end else if (en) begin
				tag_s[gi] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[gi] <= q_in | (RB'(ge) << B);
			end
		end

		if (gi < RB - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[gi] <= ge ? rem_in - trial : rem_in;
				end
			end
		end
	end

	assign out_tag = tag_s[RB-1];
	assign root    = q_s[RB-1];

endmodule
`default_nettype wire

@@ sv/segment_segment_distance.sv @@
`default_nettype none
// Least distance between two 2-D segments, one pair per cycle. Each input
// transaction carries both segments (signed Q16.16); each output transaction
// gives the distance (unsigned Q17.16, floor) and a flag that is set when the
// segments cross, touch or overlap, in which case the distance is zero. The
// pipeline takes a new pair every cycle: registered differences, products,
// orientation and squaring, one quotient bit per stage in the four restoring
// dividers, a registered minimum, and one root bit per stage in the square
// root. While an output transaction waits for tready the whole pipeline holds
// and s_axis_tready is low. collinear_tolerance is written through cfg_* and
// resets to zero.
module segment_segment_distance import ssd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// first_start_x, first_start_y, first_end_x, first_end_y,
	// second_start_x, second_start_y, second_end_x, second_end_y (32 bits each)
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// distance [32:0], segments_meet [33], zero [39:34]
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [TOL_W-1:0]      cfg_data
);

	localparam int D  = COORD_BITS + 1;
	localparam int P  = 2 * D + 1;
	localparam int SW = 2 * P;
	localparam int NW = P;
	localparam int QW = 2 * D;
	localparam int RB = D + 1;
	localparam int XW = (RB > DIST_W) ? RB : DIST_W;

	logic [TOL_W-1:0] tol_q;
	logic             en;
	ssd_tag_t         fr_tag, sq_tag;
	ssd_tag_t         tag_dl_q [QW];
	logic [SW-1:0]    dvd [LANES];
	logic [NW-1:0]    dvs [LANES];
	logic [QW-1:0]    quo [LANES];
	logic [RB-1:0]    root;
	logic [XW-1:0]    root_x;
	logic [DIST_W-1:0] dist_sat;

	// Hold every stage while the output transaction is not taken.
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	ssd_front #(.CB(COORD_BITS), .SW(SW), .NW(NW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_axis_tvalid),
		.in_data (s_axis_tdata),
		.tol     (tol_q),
		.out_tag (fr_tag),
		.dvd     (dvd),
		.dvs     (dvs)
	);

	for (genvar gl = 0; gl < LANES; gl++) begin : g_div
		ssd_div #(.SW(SW), .NW(NW), .QW(QW)) u_div (
			.clk (clk),
			.en  (en),
			.dvd (dvd[gl]),
			.dvs (dvs[gl]),
			.quo (quo[gl])
		);
	end

	// Match the divider latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) tag_dl_q[i] <= '0;
		end else if (en) begin
			tag_dl_q[0] <= fr_tag;
			for (int i = 1; i < QW; i++) tag_dl_q[i] <= tag_dl_q[i-1];
		end
	end

	ssd_sqrt #(.QW(QW), .RB(RB)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (tag_dl_q[QW-1]),
		.x       (quo),
		.out_tag (sq_tag),
		.root    (root)
	);

	assign root_x   = XW'(root);
	assign dist_sat = (root_x > XW'(DIST_MAX)) ? DIST_MAX : root_x[DIST_W-1:0];

	assign m_axis_tvalid = sq_tag.vld;
	assign m_axis_tdata  = {(OUT_DATA_W - DIST_W - 1)'(0), sq_tag.meet, dist_sat};

endmodule
`default_nettype wire

@@ sv/ssd_chk.sv @@
`default_nettype none
module ssd_chk import ssd_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [TOL_W-1:0]      cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction changed while stalled");

	a_meet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[DIST_W] |-> m_axis_tdata[DIST_W-1:0] == '0)
		else $error("meeting segments with nonzero distance");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:DIST_W+1] == '0)
		else $error("padding bits set");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline is held");

endmodule

bind segment_segment_distance ssd_chk u_ssd_chk (.*);
`default_nettype wire
